/* rtl/core/scb_pkg.sv */
package scb_pkg;

    localparam int MAX_GLYPHS     = 256;
    localparam int MAX_GLYPH_ROWS = 16;
    localparam int PIX_PER_BURST  = 8;
    localparam int FONT_DEPTH     = MAX_GLYPHS * MAX_GLYPH_ROWS;
    localparam int FONT_AW        = $clog2(FONT_DEPTH);
    localparam int PAL_DEPTH      = 16;
    localparam int PAL_AW         = $clog2(PAL_DEPTH);

    localparam logic [1:0] MODE_FONT = 2'd0;
    localparam logic [1:0] MODE_PAL  = 2'd1;
    localparam logic [1:0] MODE_DRAW = 2'd2;

    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_GLYPH_W  = 3'd2;
    localparam logic [2:0] REG_GLYPH_H  = 3'd3;
    localparam logic [2:0] REG_GLYPH_N  = 3'd4;
    localparam logic [2:0] REG_PLANAR   = 3'd5;

    typedef struct packed {
        logic [10:0] screen_width;
        logic [10:0] screen_height;
        logic [3:0]  glyph_width;
        logic [4:0]  glyph_height;
        logic [8:0]  glyph_count;
        logic        planar16_mode;
    } t_cfg;

    typedef struct packed {
        logic load_font;
        logic load_pal;
        logic latch;
        logic prep;
        logic fetch;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic draw_ok;
        logic out_free;
        logic draw_done;
    } t_stat;

endpackage

/* rtl/core/scb_ram.sv */
module scb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/scb_ctrl.sv */
module scb_ctrl import scb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_mode,
    output logic       o_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_FETCH,
        ST_RUN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        o_cmd.load_font = w_accept && (i_mode == MODE_FONT);
        o_cmd.load_pal  = w_accept && (i_mode == MODE_PAL);
        o_cmd.latch     = w_accept && (i_mode == MODE_DRAW);
        o_cmd.prep      = (r_state == ST_PREP);
        o_cmd.fetch     = (r_state == ST_FETCH);
        o_cmd.emit      = (r_state == ST_RUN) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.latch && i_stat.draw_ok) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP:  n_state = ST_FETCH;
            ST_FETCH: n_state = ST_RUN;
            ST_RUN: begin
                if (o_cmd.emit && i_stat.draw_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_stat.draw_done) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after final burst");

    a_prep_to_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |=> (r_state == ST_FETCH) && !o_ready)
        else $error("setup did not proceed to font fetch");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("input ready while a draw is in progress");

endmodule

/* rtl/core/scb_dp.sv */
module scb_dp import scb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_cfg        i_cfg,
    input  logic [7:0]  i_char_code,
    input  logic [9:0]  i_pos_x,
    input  logic [9:0]  i_pos_y,
    input  logic [7:0]  i_fore_color,
    input  logic [7:0]  i_back_color,
    input  logic        i_palette_on,
    input  logic [1:0]  i_scale,
    input  logic [11:0] i_load_index,
    input  logic [7:0]  i_load_data,
    input  logic        i_out_ready,
    output logic        o_valid,
    output logic [19:0] o_write_address,
    output logic [63:0] o_pixel_data,
    output logic [7:0]  o_byte_mask,
    output logic        o_last
);

    logic [7:0]  r_code;
    logic [9:0]  r_px;
    logic [9:0]  r_py;
    logic [7:0]  r_fg;
    logic [7:0]  r_bg;
    logic        r_pal_on;
    logic        r_sc2;
    logic [19:0] r_row_addr;
    logic [FONT_AW-1:0] r_glyph_base;
    logic [4:0]  r_cols;
    logic [5:0]  r_row_lim;
    logic        r_two;
    logic        r_burst;
    logic [5:0]  r_row_cnt;
    logic        r_rep;
    logic [3:0]  r_frow;
    logic        r_valid;
    logic [19:0] r_addr;
    logic [63:0] r_data;
    logic [7:0]  r_mask;
    logic        r_last;

    logic [3:0]  w_gw;
    logic [4:0]  w_gh;
    logic [8:0]  w_count;
    logic [19:0] w_prod;
    logic [FONT_AW-1:0] w_gbase;
    logic [4:0]  w_cols;
    logic [5:0]  w_rows;
    logic [10:0] w_avail;
    logic        w_burst_done;
    logic        w_draw_done;
    logic        w_new_frow;
    logic        w_font_re;
    logic [FONT_AW-1:0] w_font_raddr;
    logic [7:0]  w_font_q;
    logic [7:0]  w_pal_fg;
    logic [7:0]  w_pal_bg;
    logic [7:0]  w_fg;
    logic [7:0]  w_bg;
    logic [63:0] w_data;
    logic [7:0]  w_mask;

    assign w_gw    = (i_cfg.glyph_width > 4'd8) ? 4'd8 : i_cfg.glyph_width;
    assign w_gh    = (i_cfg.glyph_height > 5'(MAX_GLYPH_ROWS)) ? 5'(MAX_GLYPH_ROWS)
                                                              : i_cfg.glyph_height;
    assign w_count = (i_cfg.glyph_count > 9'(MAX_GLYPHS)) ? 9'(MAX_GLYPHS)
                                                         : i_cfg.glyph_count;

    assign o_stat.draw_ok = (i_scale != 2'd0) && ({1'b0, i_char_code} < w_count)
                         && ({1'b0, i_pos_x} < i_cfg.screen_width)
                         && ({1'b0, i_pos_y} < i_cfg.screen_height);

    // row start address only matters modulo 2^20
    assign w_prod  = 20'(r_py) * 20'(i_cfg.screen_width);
    assign w_gbase = FONT_AW'(r_code) * FONT_AW'(w_gh);
    assign w_cols  = r_sc2 ? {w_gw, 1'b0} : {1'b0, w_gw};
    assign w_rows  = r_sc2 ? {w_gh, 1'b0} : {1'b0, w_gh};
    assign w_avail = i_cfg.screen_height - {1'b0, r_py};

    assign w_burst_done = r_burst || !r_two;
    assign w_draw_done  = w_burst_done && (r_row_cnt == r_row_lim - 6'd1);
    assign w_new_frow   = !r_sc2 || r_rep;

    assign w_font_re    = i_cmd.fetch
                       || (i_cmd.emit && w_burst_done && !w_draw_done && w_new_frow);
    assign w_font_raddr = i_cmd.fetch ? r_glyph_base
                                      : r_glyph_base + FONT_AW'(r_frow) + FONT_AW'(1);

    scb_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_font),
        .i_waddr (i_load_index[FONT_AW-1:0]),
        .i_wdata (i_load_data),
        .i_re    (w_font_re),
        .i_raddr (w_font_raddr),
        .o_rdata (w_font_q)
    );

    scb_ram #(.WIDTH(8), .DEPTH(PAL_DEPTH)) u_pal_fg (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_pal),
        .i_waddr (i_load_index[PAL_AW-1:0]),
        .i_wdata (i_load_data),
        .i_re    (i_cmd.latch),
        .i_raddr (i_fore_color[PAL_AW-1:0]),
        .o_rdata (w_pal_fg)
    );

    scb_ram #(.WIDTH(8), .DEPTH(PAL_DEPTH)) u_pal_bg (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_pal),
        .i_waddr (i_load_index[PAL_AW-1:0]),
        .i_wdata (i_load_data),
        .i_re    (i_cmd.latch),
        .i_raddr (i_back_color[PAL_AW-1:0]),
        .o_rdata (w_pal_bg)
    );

    assign w_fg = (r_pal_on && !i_cfg.planar16_mode) ? w_pal_fg : r_fg;
    assign w_bg = (r_pal_on && !i_cfg.planar16_mode) ? w_pal_bg : r_bg;

    always_comb begin
        logic [3:0] fx;
        logic [2:0] col;
        logic       in_box;
        w_data = '0;
        w_mask = '0;
        for (int k = 0; k < PIX_PER_BURST; k++) begin
            fx     = {r_burst, 3'(k)};
            col    = r_sc2 ? fx[3:1] : fx[2:0];
            in_box = ({1'b0, fx} < r_cols)
                  && ((12'(r_px) + 12'(fx)) < {1'b0, i_cfg.screen_width});
            w_mask[k] = in_box;
            if (in_box) begin
                w_data[8*k +: 8] = w_font_q[3'd7 - col] ? w_fg : w_bg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_code   <= i_char_code;
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
            r_fg     <= i_fore_color;
            r_bg     <= i_back_color;
            r_pal_on <= i_palette_on;
            r_sc2    <= i_scale[1];
        end
        if (i_cmd.prep) begin
            r_glyph_base <= w_gbase;
            r_cols       <= w_cols;
            r_row_lim    <= ({5'd0, w_rows} < w_avail) ? w_rows : w_avail[5:0];
        end
        if (i_cmd.prep) begin
            r_row_addr <= w_prod + 20'(r_px);
        end else if (i_cmd.emit && w_burst_done) begin
            r_row_addr <= r_row_addr + 20'(i_cfg.screen_width);
        end
        if (i_cmd.emit) begin
            r_addr <= r_row_addr + {16'd0, r_burst, 3'd0};
            r_data <= w_data;
            r_mask <= w_mask;
            r_last <= w_draw_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two     <= 1'b0;
            r_burst   <= 1'b0;
            r_row_cnt <= '0;
            r_rep     <= 1'b0;
            r_frow    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.prep) begin
                r_two <= (w_cols > 5'd8)
                      && ((12'(r_px) + 12'd8) < {1'b0, i_cfg.screen_width});
            end
            if (i_cmd.fetch) begin
                r_burst   <= 1'b0;
                r_row_cnt <= '0;
                r_rep     <= 1'b0;
                r_frow    <= '0;
            end else if (i_cmd.emit) begin
                if (!w_burst_done) begin
                    r_burst <= 1'b1;
                end else begin
                    r_burst   <= 1'b0;
                    r_row_cnt <= r_row_cnt + 6'd1;
                    r_rep     <= r_sc2 && !r_rep;
                    if (w_new_frow) begin
                        r_frow <= r_frow + 4'd1;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free  = !r_valid || i_out_ready;
    assign o_stat.draw_done = w_draw_done;

    assign o_valid         = r_valid;
    assign o_write_address = r_addr;
    assign o_pixel_data    = r_data;
    assign o_byte_mask     = r_mask;
    assign o_last          = r_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_valid || i_out_ready))
        else $error("burst issued over a pending transfer");

    a_second_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst |-> r_two)
        else $error("second burst on a single-burst row");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_row_cnt < r_row_lim))
        else $error("burst row past the visible glyph rows");

endmodule

/* rtl/core/scaled_glyph_blitter.sv */
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tuser: mode; tdata: draw and load fields
// m_axis    out  m_axis_tvalid/tready       tdata: address, pixels, mask; tlast
// apb       in   psel/penable/pready        paddr, pwdata, prdata (6 registers)
//
// Loads and rejected draws are taken while idle and leave the sequencer idle. A draw runs
// setup (palette read, address multiply, first font read), then its bursts: visible rows
// times one or two bursts, up to 64, one burst per cycle into the output register.
// Output stalls hold the sequencer; one result register sits on the output.
// Reset is synchronous and clears control state and registers, not the stores.
module scaled_glyph_blitter import scb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // char_code, pos_x, pos_y, fore_color, back_color,
                                       // palette_on, scale, load_index, load_data
    input  logic [1:0]  s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // write_address, pixel_data, byte_mask
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        r_cfg;
    t_cmd        w_cmd;
    t_stat       w_stat;
    logic        w_cfg_we;
    logic [2:0]  w_reg;
    logic [19:0] w_addr;
    logic [63:0] w_pix;
    logic [7:0]  w_mask;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    assign w_reg    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= 11'd640;
            r_cfg.screen_height <= 11'd480;
            r_cfg.glyph_width   <= 4'd8;
            r_cfg.glyph_height  <= 5'd8;
            r_cfg.glyph_count   <= 9'd0;
            r_cfg.planar16_mode <= 1'b0;
        end else if (w_cfg_we) begin
            case (w_reg)
                REG_SCREEN_W: r_cfg.screen_width  <= pwdata[10:0];
                REG_SCREEN_H: r_cfg.screen_height <= pwdata[10:0];
                REG_GLYPH_W: begin
                    if (pwdata[3:0] != 4'd0) begin
                        r_cfg.glyph_width <= pwdata[3:0];
                    end
                end
                REG_GLYPH_H: begin
                    if (pwdata[4:0] != 5'd0) begin
                        r_cfg.glyph_height <= pwdata[4:0];
                    end
                end
                REG_GLYPH_N:  r_cfg.glyph_count   <= pwdata[8:0];
                REG_PLANAR:   r_cfg.planar16_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_SCREEN_W: prdata = {21'd0, r_cfg.screen_width};
            REG_SCREEN_H: prdata = {21'd0, r_cfg.screen_height};
            REG_GLYPH_W:  prdata = {28'd0, r_cfg.glyph_width};
            REG_GLYPH_H:  prdata = {27'd0, r_cfg.glyph_height};
            REG_GLYPH_N:  prdata = {23'd0, r_cfg.glyph_count};
            REG_PLANAR:   prdata = {31'd0, r_cfg.planar16_mode};
            default:      prdata = '0;
        endcase
    end

    scb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    scb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg           (r_cfg),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_pos_x         (s_axis_tdata[17:8]),
        .i_pos_y         (s_axis_tdata[27:18]),
        .i_fore_color    (s_axis_tdata[35:28]),
        .i_back_color    (s_axis_tdata[43:36]),
        .i_palette_on    (s_axis_tdata[44]),
        .i_scale         (s_axis_tdata[46:45]),
        .i_load_index    (s_axis_tdata[58:47]),
        .i_load_data     (s_axis_tdata[66:59]),
        .i_out_ready     (m_axis_tready),
        .o_valid         (m_axis_tvalid),
        .o_write_address (w_addr),
        .o_pixel_data    (w_pix),
        .o_byte_mask     (w_mask),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_mask, w_pix, w_addr};

endmodule
